@@ rtl/signed_distance_transform_defines.svh @@
// assertion macros for the signed distance transform block
// taken in by the top level; the bodies are empty when SYNTH is defined
`ifndef SIGNED_DISTANCE_TRANSFORM_DEFINES_SVH
`define SIGNED_DISTANCE_TRANSFORM_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SDT_ASSERT_NOW(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("sdt assertion failed");
// next-cycle implication
`define SDT_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("sdt assertion failed");
`else
`define SDT_ASSERT_NOW(lbl, clk, rst, a, b)
`define SDT_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

@@ rtl/sdt_pkg.sv @@
// shared types and constants of the signed distance transform block
// no dependencies; imported by the top level, sdt_map and the testbench
`timescale 1ns / 1ps
package sdt_pkg;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 9;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_RUN  = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [CSR_IW-1:0] CSR_WIDTH   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_HEIGHT  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MAXDIST = 2'd2;

   localparam logic [CSR_DW-1:0] WIDTH_RESET   = 9'd256;
   localparam logic [CSR_DW-1:0] HEIGHT_RESET  = 9'd256;
   localparam logic [7:0]        MAXDIST_RESET = 8'd80;

   localparam logic [7:0] GREY_MAX = 8'd255;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] pixel_value;
   } sdt_req_type;

   typedef struct packed {
      logic [7:0] field_value;
      logic       done_res;
   } sdt_rsp_type;

   // round(sqrt(2) * 2^frac), halves up; evaluated at elaboration
   function automatic longint diag_step(input int frac);
      longint v;
      longint r;
      longint b;
      v = longint'(2) << (2 * frac + 2);
      r = 0;
      b = longint'(1) << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) begin
            b = b >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return (r + 1) >> 1;
   endfunction

endpackage

@@ rtl/signed_distance_transform.sv @@
// load: one beat per cycle while the result side does not stall. read: runs the 8-step
// grey divider unless the grey value saturates. run: marks borders pixel by pixel, then
// two raster passes compare each pixel with its neighbours (a neighbour clamped onto the
// centre is skipped) and take a square root for each improving neighbour; all through
// image, distance and nearest rams with one read and one write port each.
// reset clears control and configuration only; pixel memories hold garbage until written
`timescale 1ns / 1ps
`include "signed_distance_transform_defines.svh"
module signed_distance_transform
   import sdt_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sdt_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sdt_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW   = $clog2(NPIX);
   localparam int WXW  = $clog2(MAX_WIDTH + 1);
   localparam int WYW  = $clog2(MAX_HEIGHT + 1);
   localparam int CWA  = (WXW > WYW) ? WXW : WYW;
   localparam int CW   = (CWA > CSR_DW) ? CWA : CSR_DW;
   localparam int DWA  = $clog2(((MAX_WIDTH + MAX_HEIGHT) << FRAC_BITS) + 1);
   localparam int DWB  = FRAC_BITS + 8;
   localparam int DW   = (DWA > DWB) ? DWA : DWB;
   localparam int NW   = XW + YW;
   localparam int XYW  = (XW > YW) ? XW : YW;
   localparam int SQW  = 2 * XYW + 1;
   localparam int RW   = SQW + 2 * FRAC_BITS + 2;

   localparam logic [DW:0]   STEP_DIRECT = (DW + 1)'(1) << FRAC_BITS;
   localparam logic [DW:0]   STEP_DIAG   = (DW + 1)'(diag_step(FRAC_BITS));
   localparam logic [DW-1:0] DIST_INF    = '1;

   // border taps: centre, left, right, up, down
   localparam logic [2:0] TAP_CEN   = 3'd0;
   localparam logic [2:0] TAP_LEFT  = 3'd1;
   localparam logic [2:0] TAP_RIGHT = 3'd2;
   localparam logic [2:0] TAP_UP    = 3'd3;
   localparam logic [2:0] TAP_DOWN  = 3'd4;
   localparam logic [2:0] TAP_END   = 3'd5;
   localparam logic [2:0] PASS_END  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ_WAIT, ST_MAP, ST_B_SCAN, ST_P_CEN, ST_P_LOAD,
      ST_P_NBR, ST_P_CMP, ST_P_MUL, ST_P_SQS, ST_P_SQ, ST_P_WR
   } state_type;

   state_type         state_ff, state_in;
   logic [XW-1:0]     x_ff, x_in;
   logic [YW-1:0]     y_ff, y_in;
   logic [2:0]        k_ff, k_in;
   logic              bwd_ff, bwd_in;
   logic              border_ff, border_in;
   logic [7:0]        cen_pix_ff, cen_pix_in;
   logic [DW-1:0]     cur_dist_ff, cur_dist_in;
   logic [NW-1:0]     cur_near_ff, cur_near_in;
   logic [XW-1:0]     dx_ff, dx_in;
   logic [YW-1:0]     dy_ff, dy_in;
   logic [SQW-1:0]    sumsq_ff, sumsq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sdt_rsp_type       rsp_ff, rsp_in;
   logic [CSR_DW-1:0] cfg_w_ff, cfg_w_in;
   logic [CSR_DW-1:0] cfg_h_ff, cfg_h_in;
   logic [7:0]        cfg_md_ff, cfg_md_in;

   // memories
   logic [7:0]    img_mem  [NPIX];
   logic [DW-1:0] dist_mem [NPIX];
   logic [NW-1:0] near_mem [NPIX];
   logic [7:0]    img_rd_ff;
   logic [DW-1:0] dist_rd_ff;
   logic [NW-1:0] near_rd_ff;
   logic          img_we, dn_we;
   logic [AW-1:0] img_waddr, img_raddr, dn_waddr, dn_raddr;
   logic [7:0]    img_wdata;
   logic [DW-1:0] dn_wdist;
   logic [NW-1:0] dn_wnear;

   logic          req_acc, req_inside;
   logic [CW-1:0] eff_w, eff_h, col_ext, row_ext;
   logic [XW-1:0] w_last, xm, xp, qx, ncol;
   logic [YW-1:0] h_last, ym, yp, qy, nrow;
   logic [AW-1:0] req_addr, cur_addr, b_addr;
   logic          nb_ok, bcmp, border_now, q_same, take, last_px;
   logic [DW:0]   step;
   logic          map_start, map_done, sq_start, sq_done;
   logic [7:0]    map_value;
   logic [DW-1:0] sq_result;

   function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] px,
                                              input logic [YW-1:0] py);
      return AW'(AW'(py) * AW'(MAX_WIDTH)) + AW'(px);
   endfunction

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= img_wdata;
      end
      img_rd_ff <= img_mem[img_raddr];
   end

   always_ff @(posedge clock) begin
      if (dn_we) begin
         dist_mem[dn_waddr] <= dn_wdist;
         near_mem[dn_waddr] <= dn_wnear;
      end
      dist_rd_ff <= dist_mem[dn_raddr];
      near_rd_ff <= near_mem[dn_raddr];
   end

   sdt_map #(
      .FRAC_BITS (FRAC_BITS),
      .DIST_W    (DW)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .start    (map_start),
      .is_zero  (img_rd_ff == 8'd0),
      .distance (dist_rd_ff),
      .max_dist (cfg_md_ff),
      .done     (map_done),
      .value    (map_value)
   );

   sdt_sqrt #(
      .RAD_W (RW),
      .OUT_W (DW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({sumsq_ff, {(2 * FRAC_BITS + 2){1'b0}}}),
      .done     (sq_done),
      .result   (sq_result)
   );

   // geometry and neighbour addressing
   always_comb begin
      eff_w = (cfg_w_ff == '0) ? CW'(1) :
              ((CW'(cfg_w_ff) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(cfg_w_ff));
      eff_h = (cfg_h_ff == '0) ? CW'(1) :
              ((CW'(cfg_h_ff) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(cfg_h_ff));
      w_last     = XW'(eff_w - CW'(1));
      h_last     = YW'(eff_h - CW'(1));
      col_ext    = CW'(req_data.col);
      row_ext    = CW'(req_data.row);
      req_inside = (col_ext < eff_w) && (row_ext < eff_h);
      req_acc    = req_valid && !req_stall;
      req_addr   = pix_addr(col_ext[XW-1:0], row_ext[YW-1:0]);
      cur_addr   = pix_addr(x_ff, y_ff);
      xm = (x_ff == '0) ? x_ff : x_ff - XW'(1);
      xp = (x_ff == w_last) ? x_ff : x_ff + XW'(1);
      ym = (y_ff == '0) ? y_ff : y_ff - YW'(1);
      yp = (y_ff == h_last) ? y_ff : y_ff + YW'(1);

      case (k_ff)
         TAP_LEFT:  b_addr = pix_addr(xm, y_ff);
         TAP_RIGHT: b_addr = pix_addr(xp, y_ff);
         TAP_UP:    b_addr = pix_addr(x_ff, ym);
         TAP_DOWN:  b_addr = pix_addr(x_ff, yp);
         default:   b_addr = cur_addr;
      endcase

      // data of tap k-1 arrives while k is current; outside counts as equal
      case (k_ff)
         TAP_RIGHT: nb_ok = (x_ff != '0);
         TAP_UP:    nb_ok = (x_ff != w_last);
         TAP_DOWN:  nb_ok = (y_ff != '0);
         TAP_END:   nb_ok = (y_ff != h_last);
         default:   nb_ok = 1'b0;
      endcase
      bcmp       = nb_ok && (img_rd_ff != cen_pix_ff);
      border_now = border_ff || bcmp;

      case ({bwd_ff, k_ff[1:0]})
         3'b000:  begin qx = xm;   qy = ym;   step = STEP_DIAG;   end
         3'b001:  begin qx = x_ff; qy = ym;   step = STEP_DIRECT; end
         3'b010:  begin qx = xp;   qy = ym;   step = STEP_DIAG;   end
         3'b011:  begin qx = xm;   qy = y_ff; step = STEP_DIRECT; end
         3'b100:  begin qx = xp;   qy = y_ff; step = STEP_DIRECT; end
         3'b101:  begin qx = xm;   qy = yp;   step = STEP_DIAG;   end
         3'b110:  begin qx = x_ff; qy = yp;   step = STEP_DIRECT; end
         default: begin qx = xp;   qy = yp;   step = STEP_DIAG;   end
      endcase
      // a clamped neighbour equal to the centre can never improve it
      q_same = (qx == x_ff) && (qy == y_ff);
      take   = ({1'b0, dist_rd_ff} + step) < {1'b0, cur_dist_ff};
      ncol   = near_rd_ff[XW-1:0];
      nrow   = near_rd_ff[NW-1:XW];
      last_px = bwd_ff ? ((x_ff == '0) && (y_ff == '0))
                       : ((x_ff == w_last) && (y_ff == h_last));
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      bwd_in       = bwd_ff;
      border_in    = border_ff;
      cen_pix_in   = cen_pix_ff;
      cur_dist_in  = cur_dist_ff;
      cur_near_in  = cur_near_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sumsq_in     = sumsq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cfg_w_in     = cfg_w_ff;
      cfg_h_in     = cfg_h_ff;
      cfg_md_in    = cfg_md_ff;
      img_we       = 1'b0;
      img_waddr    = req_addr;
      img_wdata    = req_data.pixel_value;
      img_raddr    = req_addr;
      dn_we        = 1'b0;
      dn_waddr     = cur_addr;
      dn_wdist     = cur_dist_ff;
      dn_wnear     = cur_near_ff;
      dn_raddr     = req_addr;
      map_start    = 1'b0;
      sq_start     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:   cfg_w_in  = csr_wdata;
            CSR_HEIGHT:  cfg_h_in  = csr_wdata;
            CSR_MAXDIST: cfg_md_in = csr_wdata[7:0];
            default:     ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rsp_in.field_value = '0;
               rsp_in.done_res    = 1'b0;
               case (req_data.action)
                  ACT_LOAD: begin
                     img_we          = req_inside;
                     rsp_in.done_res = req_inside;
                     rsp_valid_in    = 1'b1;
                  end
                  ACT_RUN: begin
                     x_in      = '0;
                     y_in      = '0;
                     k_in      = TAP_CEN;
                     bwd_in    = 1'b0;
                     border_in = 1'b0;
                     state_in  = ST_B_SCAN;
                  end
                  ACT_READ: begin
                     if (req_inside) begin
                        state_in = ST_READ_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ_WAIT: begin
            map_start = 1'b1;
            state_in  = ST_MAP;
         end
         ST_MAP: begin
            if (map_done) begin
               rsp_in.field_value = map_value;
               rsp_in.done_res    = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_B_SCAN: begin
            img_raddr = b_addr;
            if (k_ff == TAP_LEFT) begin
               cen_pix_in = img_rd_ff;
            end
            if (bcmp) begin
               border_in = 1'b1;
            end
            if (k_ff == TAP_END) begin
               dn_we     = 1'b1;
               dn_wdist  = border_now ? '0 : DIST_INF;
               dn_wnear  = border_now ? {y_ff, x_ff} : '0;
               k_in      = TAP_CEN;
               border_in = 1'b0;
               if (last_px) begin
                  x_in     = '0;
                  y_in     = '0;
                  bwd_in   = 1'b0;
                  state_in = ST_P_CEN;
               end else if (x_ff == w_last) begin
                  x_in = '0;
                  y_in = y_ff + YW'(1);
               end else begin
                  x_in = x_ff + XW'(1);
               end
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_P_CEN: begin
            dn_raddr = cur_addr;
            state_in = ST_P_LOAD;
         end
         ST_P_LOAD: begin
            cur_dist_in = dist_rd_ff;
            cur_near_in = near_rd_ff;
            k_in        = '0;
            state_in    = ST_P_NBR;
         end
         ST_P_NBR: begin
            if (k_ff == PASS_END) begin
               state_in = ST_P_WR;
            end else if (q_same) begin
               k_in = k_ff + 3'd1;
            end else begin
               dn_raddr = pix_addr(qx, qy);
               state_in = ST_P_CMP;
            end
         end
         ST_P_CMP: begin
            if (take) begin
               cur_near_in = near_rd_ff;
               dx_in       = (x_ff > ncol) ? x_ff - ncol : ncol - x_ff;
               dy_in       = (y_ff > nrow) ? y_ff - nrow : nrow - y_ff;
               state_in    = ST_P_MUL;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_P_NBR;
            end
         end
         ST_P_MUL: begin
            sumsq_in = SQW'(SQW'(dx_ff) * SQW'(dx_ff)) + SQW'(SQW'(dy_ff) * SQW'(dy_ff));
            state_in = ST_P_SQS;
         end
         ST_P_SQS: begin
            sq_start = 1'b1;
            state_in = ST_P_SQ;
         end
         ST_P_SQ: begin
            if (sq_done) begin
               cur_dist_in = sq_result;
               k_in        = k_ff + 3'd1;
               state_in    = ST_P_NBR;
            end
         end
         ST_P_WR: begin
            dn_we    = 1'b1;
            state_in = ST_P_CEN;
            if (last_px) begin
               if (!bwd_ff) begin
                  bwd_in = 1'b1;
                  x_in   = w_last;
                  y_in   = h_last;
               end else begin
                  rsp_in.field_value = '0;
                  rsp_in.done_res    = 1'b1;
                  rsp_valid_in       = 1'b1;
                  state_in           = ST_IDLE;
               end
            end else if (bwd_ff) begin
               if (x_ff == '0) begin
                  x_in = w_last;
                  y_in = y_ff - YW'(1);
               end else begin
                  x_in = x_ff - XW'(1);
               end
            end else if (x_ff == w_last) begin
               x_in = '0;
               y_in = y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_w_ff     <= WIDTH_RESET;
         cfg_h_ff     <= HEIGHT_RESET;
         cfg_md_ff    <= MAXDIST_RESET;
         k_ff         <= '0;
         bwd_ff       <= 1'b0;
         border_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_w_ff     <= cfg_w_in;
         cfg_h_ff     <= cfg_h_in;
         cfg_md_ff    <= cfg_md_in;
         k_ff         <= k_in;
         bwd_ff       <= bwd_in;
         border_ff    <= border_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      cen_pix_ff  <= cen_pix_in;
      cur_dist_ff <= cur_dist_in;
      cur_near_ff <= cur_near_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sumsq_ff    <= sumsq_in;
      rsp_ff      <= rsp_in;
   end

   // one beat at a time; the output register frees the input side when it drains
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SDT_ASSERT_NEXT(a_load_answers, clock, reset, req_acc && req_data.action == ACT_LOAD, rsp_valid_ff)
   `SDT_ASSERT_NOW(a_busy_no_beat, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff)
   `SDT_ASSERT_NOW(a_sqrt_in_pass, clock, reset, sq_done, state_ff == ST_P_SQ)
   `SDT_ASSERT_NOW(a_map_in_read, clock, reset, map_done, state_ff == ST_MAP)

endmodule

@@ rtl/sdt_sqrt.sv @@
// bit-serial integer square root, one root bit per cycle, result rounded halves up
// depends on nothing but its parameters
`timescale 1ns / 1ps
module sdt_sqrt #(
   parameter int RAD_W = 35,
   parameter int OUT_W = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RAD_W-1:0] radicand,
   output logic             done,
   output logic [OUT_W-1:0] result
);

   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int VW     = 2 * ROOT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW-1:0] v_ff, v_in;
   logic [VW-1:0] r_ff, r_in;
   logic [VW-1:0] b_ff, b_in;
   logic [VW-1:0] trial;
   logic [OUT_W-1:0] result_ff, result_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      v_in      = v_ff;
      r_in      = r_ff;
      b_in      = b_ff;
      result_in = result_ff;
      trial     = r_ff + b_ff;
      if (start) begin
         v_in    = VW'(radicand);
         r_in    = '0;
         b_in    = VW'(1) << (VW - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff == VW'(1)) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = OUT_W'((r_in + VW'(1)) >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff      <= v_in;
      r_ff      <= r_in;
      b_ff      <= b_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ rtl/sdt_map.sv @@
// maps a fixed-point distance to an 8-bit grey value with an 8-step restoring divider
// depends on sdt_pkg
`timescale 1ns / 1ps
module sdt_map
   import sdt_pkg::*;
#(
   parameter int FRAC_BITS = 8,
   parameter int DIST_W    = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              is_zero,
   input  logic [DIST_W-1:0] distance,
   input  logic [7:0]        max_dist,
   output logic              done,
   output logic [7:0]        value
);

   localparam int MW = FRAC_BITS + 8;
   localparam int NW = ((DIST_W > MW) ? DIST_W : MW) + 1;
   localparam int LW = NW + 8;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW-1:0] dsh_ff, dsh_in;
   logic [7:0]    q_ff, q_in;
   logic [7:0]    md_eff;
   logic [LW-1:0] m, d_ext, n;

   always_comb begin
      md_eff  = (max_dist == 8'd0) ? 8'd1 : max_dist;
      m       = LW'(md_eff) << FRAC_BITS;
      d_ext   = LW'(distance);
      n       = is_zero ? (m - d_ext) : (m + d_ext);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         if (is_zero && d_ext >= m) begin
            q_in    = '0;
            done_in = 1'b1;
         end else if (n >= (m << 1)) begin
            q_in    = GREY_MAX;
            done_in = 1'b1;
         end else begin
            // numerator 255*n, divisor 2m aligned for the top quotient bit
            rem_in  = (n << 8) - n;
            dsh_in  = m << 8;
            cnt_in  = 3'd7;
            q_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = q_ff | (8'd1 << cnt_ff);
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign value = q_ff;

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the signed distance transform block
// depends on sdt_pkg and the signed_distance_transform rtl; holds its own frame model
`timescale 1ns / 1ps
module tb_top;
   import sdt_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int FRAC = 8;
   localparam int ROW_PITCH = 256;
   localparam int unsigned FAR_AWAY = 32'hFFFF_FFFF;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   sdt_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   sdt_rsp_type       rsp_data;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   signed_distance_transform i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // frame model
   logic [7:0]  grey_m [ROW_PITCH*256];
   int unsigned dist_m [ROW_PITCH*256];
   logic [15:0] near_x [ROW_PITCH*256];
   logic [15:0] near_y [ROW_PITCH*256];
   int unsigned frame_w;
   int unsigned frame_h;
   int unsigned span;

   sdt_rsp_type pending_rsp[$];
   int          errors;
   int          items;
   bit          quiet;
   int          hold;

   typedef struct {
      bit          is_csr;
      logic [1:0]  csr_idx;
      int          csr_val;
      sdt_req_type req;
      bit          typed;
      sdt_rsp_type rsp;
   } plan_row_type;

   plan_row_type plan [26];

   function automatic longint unsigned int_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int unsigned hypot_fx(input int unsigned dx, input int unsigned dy);
      longint unsigned v;
      v = longint'(dx) * dx + longint'(dy) * dy;
      return int'((int_root(v << (2 * FRAC + 2)) + 1) >> 1);
   endfunction

   function automatic int unsigned clip(input int v, input int unsigned n);
      if (v < 0) return 0;
      if (v > int'(n) - 1) return n - 1;
      return v;
   endfunction

   function automatic void relax(input int x, input int y, input int qx, input int qy,
                                 input int unsigned step);
      int unsigned p;
      int unsigned q;
      int dx;
      int dy;
      p = y * ROW_PITCH + x;
      q = clip(qy, frame_h) * ROW_PITCH + clip(qx, frame_w);
      if (longint'(dist_m[q]) + step < longint'(dist_m[p])) begin
         near_x[p] = near_x[q];
         near_y[p] = near_y[q];
         dx = x - int'(near_x[p]);
         dy = y - int'(near_y[p]);
         dist_m[p] = hypot_fx(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
      end
   endfunction

   function automatic void sweep_frame();
      int unsigned w;
      int unsigned h;
      int unsigned p;
      int unsigned dg;
      logic [7:0] c;
      bit edge_px;
      w = frame_w;
      h = frame_h;
      dg = hypot_fx(1, 1);
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            p = y * ROW_PITCH + x;
            c = grey_m[p];
            edge_px = (x > 0 && grey_m[p-1] != c) || (x + 1 < w && grey_m[p+1] != c) ||
                      (y > 0 && grey_m[p-ROW_PITCH] != c) ||
                      (y + 1 < h && grey_m[p+ROW_PITCH] != c);
            dist_m[p] = edge_px ? 0 : FAR_AWAY;
            near_x[p] = edge_px ? 16'(x) : 16'd0;
            near_y[p] = edge_px ? 16'(y) : 16'd0;
         end
      end
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            relax(x, y, x - 1, y - 1, dg);
            relax(x, y, x, y - 1, 256);
            relax(x, y, x + 1, y - 1, dg);
            relax(x, y, x - 1, y, 256);
         end
      end
      for (int y = h - 1; y >= 0; y--) begin
         for (int x = w - 1; x >= 0; x--) begin
            relax(x, y, x + 1, y, 256);
            relax(x, y, x - 1, y + 1, dg);
            relax(x, y, x, y + 1, 256);
            relax(x, y, x + 1, y + 1, dg);
         end
      end
   endfunction

   function automatic logic [7:0] grey_of(input int unsigned p);
      longint unsigned m;
      longint unsigned d;
      longint unsigned n;
      longint unsigned g;
      m = longint'(span) << FRAC;
      d = dist_m[p];
      if (grey_m[p] == 0) begin
         if (d >= m) return 0;
         n = m - d;
      end else begin
         n = m + d;
      end
      g = (255 * n) / (2 * m);
      return g > 255 ? GREY_MAX : g[7:0];
   endfunction

   function automatic sdt_rsp_type predict_beat(input sdt_req_type r);
      sdt_rsp_type o;
      bit in_frame;
      int unsigned p;
      o = '0;
      in_frame = r.col < frame_w && r.row < frame_h;
      p = r.row * ROW_PITCH + r.col;
      case (r.action)
         ACT_LOAD: begin
            if (in_frame) begin
               grey_m[p] = r.pixel_value;
               o.done_res = 1'b1;
            end
         end
         ACT_RUN: begin
            sweep_frame();
            o.done_res = 1'b1;
         end
         ACT_READ: begin
            if (in_frame) begin
               o.field_value = grey_of(p);
               o.done_res = 1'b1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // result side: random stall after each beat, checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            if (rsp_data.field_value !== pending_rsp[0].field_value) begin
               $display("%0t: field_value expected %0d actual %0d", $time,
                        pending_rsp[0].field_value, rsp_data.field_value);
               errors++;
            end
            if (rsp_data.done_res !== pending_rsp[0].done_res) begin
               $display("%0t: done_res expected %0d actual %0d", $time,
                        pending_rsp[0].done_res, rsp_data.done_res);
               errors++;
            end
            void'(pending_rsp.pop_front());
         end
         hold = quiet ? 0 : $urandom_range(0, 3);
      end else if (hold > 0) begin
         hold--;
      end
      rsp_stall <= (hold > 0);
   end

   task automatic send_beat(input sdt_req_type r, input bit typed, input sdt_rsp_type t);
      int gap;
      sdt_rsp_type o;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      o = predict_beat(r);
      pending_rsp = {pending_rsp, typed ? t : o};
      items++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DW'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_WIDTH:   frame_w = val;
         CSR_HEIGHT:  frame_h = val;
         CSR_MAXDIST: span = val;
         default: ;
      endcase
   endtask

   initial begin
      sdt_req_type r;
      int w;
      int h;
      int ops;
      int mode;
      int pick;
      logic [7:0] flat;
      errors = 0;
      items = 0;
      hold = 0;
      quiet = 0;
      frame_w = WIDTH_RESET;
      frame_h = HEIGHT_RESET;
      span = MAXDIST_RESET;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      plan = '{
         '{0, 0, 0, '{ACT_LOAD, 8'd0, 8'd0, 8'd0}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd255, 8'd255, 8'd255}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_NONE, 8'd255, 8'd255, 8'd255}, 1, '{8'd0, 1'b0}},
         '{1, CSR_WIDTH, 2, '{ACT_NONE, 8'd0, 8'd0, 8'd0}, 0, '{8'd0, 1'b0}},
         '{1, CSR_HEIGHT, 2, '{ACT_NONE, 8'd0, 8'd0, 8'd0}, 0, '{8'd0, 1'b0}},
         '{1, CSR_MAXDIST, 255, '{ACT_NONE, 8'd0, 8'd0, 8'd0}, 0, '{8'd0, 1'b0}},
         '{0, 0, 0, '{ACT_LOAD, 8'd0, 8'd0, 8'd7}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd1, 8'd0, 8'd7}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd0, 8'd1, 8'd7}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd1, 8'd1, 8'd7}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_RUN, 8'd0, 8'd0, 8'd0}, 1, '{8'd0, 1'b1}},
         // flat nonzero frame has no border
         '{0, 0, 0, '{ACT_READ, 8'd0, 8'd0, 8'd0}, 1, '{8'd255, 1'b1}},
         '{0, 0, 0, '{ACT_READ, 8'd2, 8'd0, 8'd0}, 1, '{8'd0, 1'b0}},
         '{0, 0, 0, '{ACT_LOAD, 8'd0, 8'd2, 8'd9}, 1, '{8'd0, 1'b0}},
         '{0, 0, 0, '{ACT_LOAD, 8'd0, 8'd0, 8'd0}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd1, 8'd0, 8'd0}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd0, 8'd1, 8'd0}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd1, 8'd1, 8'd0}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_RUN, 8'd0, 8'd0, 8'd0}, 1, '{8'd0, 1'b1}},
         // flat zero frame has no border
         '{0, 0, 0, '{ACT_READ, 8'd1, 8'd1, 8'd0}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_LOAD, 8'd0, 8'd0, 8'd255}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_RUN, 8'd0, 8'd0, 8'd0}, 1, '{8'd0, 1'b1}},
         '{0, 0, 0, '{ACT_READ, 8'd1, 8'd1, 8'd0}, 0, '{8'd0, 1'b0}},
         '{1, CSR_MAXDIST, 1, '{ACT_NONE, 8'd0, 8'd0, 8'd0}, 0, '{8'd0, 1'b0}},
         '{0, 0, 0, '{ACT_READ, 8'd0, 8'd0, 8'd0}, 0, '{8'd0, 1'b0}},
         '{0, 0, 0, '{ACT_READ, 8'd1, 8'd0, 8'd0}, 0, '{8'd0, 1'b0}}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain();
            write_reg(plan[i].csr_idx, plan[i].csr_val);
         end else begin
            send_beat(plan[i].req, plan[i].typed, plan[i].rsp);
         end
      end

      while (items < 1250) begin
         // registers change only with nothing in flight
         drain();
         quiet = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 15);
         case (pick)
            0: begin w = 256; h = 1; end
            1: begin w = 1; h = 256; end
            2: begin w = 1; h = 1; end
            default: begin w = $urandom_range(1, 7); h = $urandom_range(1, 7); end
         endcase
         write_reg(CSR_WIDTH, w);
         write_reg(CSR_HEIGHT, h);
         pick = $urandom_range(0, 5);
         write_reg(CSR_MAXDIST, pick == 0 ? 1 : pick == 1 ? 255 : $urandom_range(1, 255));
         mode = $urandom_range(0, 2);
         flat = 8'($urandom_range(1, 255));
         for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
               r.action = ACT_LOAD;
               r.col = 8'(x);
               r.row = 8'(y);
               case (mode)
                  0: r.pixel_value = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
                  1: r.pixel_value = $urandom_range(0, 1) ? 8'd0 : flat;
                  default: r.pixel_value = 8'($urandom_range(0, 255));
               endcase
               send_beat(r, 0, '0);
            end
         end
         r = '{ACT_RUN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255))};
         send_beat(r, 0, '0);
         ops = $urandom_range(10, 40);
         for (int k = 0; k < ops; k++) begin
            pick = $urandom_range(0, 99);
            r.col = 8'($urandom_range(0, w - 1));
            r.row = 8'($urandom_range(0, h - 1));
            r.pixel_value = 8'($urandom_range(0, 255));
            if (pick < 60) begin
               r.action = ACT_READ;
            end else if (pick < 75) begin
               r.action = ACT_LOAD;
            end else if (pick < 88) begin
               r.action = $urandom_range(0, 1) ? ACT_READ : ACT_LOAD;
               if (w < 256) r.col = 8'($urandom_range(w, 255));
               r.row = 8'($urandom_range(0, 255));
            end else if (pick < 94) begin
               r.action = ACT_NONE;
               r.col = 8'($urandom_range(0, 255));
               r.row = 8'($urandom_range(0, 255));
            end else begin
               r.action = ACT_RUN;
            end
            send_beat(r, 0, '0);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
